// File: design/gss_pkg.sv
// shared types and constants for the gauss-seidel solver
`timescale 1ns / 1ps
package gss_pkg;

  localparam int MAX_N = 16;
  localparam int IDX_W = $clog2(MAX_N);
  localparam int VALUE_WIDTH = 32;
  localparam int ACC_W = 64;
  localparam int QUO_W = 64;

  localparam logic [1:0] CMD_COEFF = 2'd0;
  localparam logic [1:0] CMD_RHS   = 2'd1;
  localparam logic [1:0] CMD_GUESS = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_ZDIAG = 2'd2;

  localparam logic [1:0] REG_SIZE = 2'd0;
  localparam logic [1:0] REG_TOL  = 2'd1;
  localparam logic [1:0] REG_MAXS = 2'd2;

  localparam logic [4:0]  SIZE_RST = 5'd16;
  localparam logic [30:0] TOL_RST  = 31'd66;
  localparam logic [27:0] MAXS_RST = 28'd200000000;

  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;
  } in_word_t;

  typedef struct packed {
    logic [3:0]         var_index;
    logic signed [31:0] solution;
    logic [1:0]         status;
    logic [28:0]        sweeps;
    logic               last;
  } out_word_t;

  // queue entry between front and back: start request with clipped size
  typedef struct packed {
    logic [IDX_W:0] n;
    logic [30:0]    tol;
    logic [27:0]    max_sweeps;
  } job_t;

endpackage

// File: design/gss_front.sv
// front end: takes command words, writes stores, queues start requests
`timescale 1ns / 1ps
module gss_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  gss_pkg::in_word_t   in_word,
  input  logic [4:0]          size_cfg,
  input  logic [30:0]         tol_cfg,
  input  logic [27:0]         maxs_cfg,
  input  logic                job_taken,
  input  logic                back_idle,
  output logic                busy,
  output logic                wr_en,
  output logic [1:0]          wr_sel,
  output logic [7:0]          wr_addr,
  output logic signed [31:0]  wr_data,
  output logic                job_valid,
  output gss_pkg::job_t       job
);

  logic          pend_r, pend_nxt;
  gss_pkg::job_t job_r, job_nxt;
  logic          acc;
  logic [4:0]    n_clip;

  assign busy = pend_r || !back_idle;
  assign acc  = start && !busy;

  always_comb begin
    if (size_cfg == 5'd0) begin
      n_clip = 5'd1;
    end else if (size_cfg > 5'(gss_pkg::MAX_N)) begin
      n_clip = 5'(gss_pkg::MAX_N);
    end else begin
      n_clip = size_cfg;
    end
  end

  assign wr_en   = acc && (in_word.cmd != gss_pkg::CMD_START);
  assign wr_sel  = in_word.cmd;
  assign wr_addr = (in_word.cmd == gss_pkg::CMD_COEFF) ? {in_word.row, in_word.col}
                                                       : {4'd0, in_word.row};
  assign wr_data = in_word.value;

  always_comb begin
    pend_nxt = pend_r;
    job_nxt  = job_r;
    if (job_taken) begin
      pend_nxt = 1'b0;
    end
    if (acc && in_word.cmd == gss_pkg::CMD_START) begin
      pend_nxt = 1'b1;
      job_nxt  = '{n: n_clip, tol: tol_cfg, max_sweeps: maxs_cfg};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
    end
    job_r <= job_nxt;
  end

  assign job_valid = pend_r;
  assign job       = job_r;

endmodule

// File: design/gss_div.sv
// radix-2 signed divider, 64-bit dividend by 32-bit divisor, truncating
`timescale 1ns / 1ps
module gss_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [63:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [63:0] quotient
);

  logic        run_r, run_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [31:0] dv_r, dv_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [64:0] sh;

  always_comb begin
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    sh       = {rem_r[63:0], q_r[63]};
    if (go) begin
      run_nxt = 1'b1;
      cnt_nxt = 7'd0;
      q_nxt   = dividend[63] ? 64'(-dividend) : 64'(dividend);
      rem_nxt = '0;
      dv_nxt  = divisor[31] ? 32'(-divisor) : 32'(divisor);
      neg_nxt = dividend[63] ^ divisor[31];
    end else if (run_r) begin
      if (sh >= {33'd0, dv_r}) begin
        rem_nxt = sh - {33'd0, dv_r};
        q_nxt   = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
    neg_r <= neg_nxt;
  end

  assign done     = done_r;
  assign quotient = neg_r ? -$signed(q_r) : $signed(q_r);

endmodule

// File: design/gss_back.sv
// back end: holds the stores and runs sweeps and result reporting
`timescale 1ns / 1ps
module gss_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [1:0]          wr_sel,
  input  logic [7:0]          wr_addr,
  input  logic signed [31:0]  wr_data,
  input  logic                job_valid,
  input  gss_pkg::job_t       job,
  output logic                job_taken,
  output logic                idle,
  output logic                out_valid,
  output gss_pkg::out_word_t  out_word
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DCHK  = 8'b0000_0010,
    S_INIT  = 8'b0000_0100,
    S_MAC   = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_RPT   = 8'b0100_0000,
    S_RPTW  = 8'b1000_0000
  } state_t;

  logic signed [31:0] coeff_mem [256];
  logic signed [31:0] rhs_mem [16];
  logic signed [31:0] sol_mem [16];

  state_t             st_r, st_nxt;
  gss_pkg::job_t      jb_r;
  logic [3:0]         i_r, i_nxt;
  logic [4:0]         j_r, j_nxt;
  logic [28:0]        sw_r, sw_nxt;
  logic [4:0]         set_r, set_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [63:0] prod_r;
  logic signed [31:0] a_rd_r, x_rd_r, diag_r, old_r, rhs_rd_r;
  logic               prod_v_r;
  logic               div_go, div_done;
  logic signed [63:0] quo;
  logic signed [31:0] q_sat;
  logic signed [33:0] dlt;
  logic [33:0]        dabs;
  logic               sol_we;
  logic [3:0]         sol_wa;
  logic signed [31:0] sol_wd;
  logic               ov_r, ov_nxt;
  gss_pkg::out_word_t ow_r, ow_nxt;
  logic [4:0]         rd_j;
  logic               zd_r, zd_nxt;
  logic               last_i;
  logic signed [63:0] acc_sub;

  gss_div u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(acc_r),
    .divisor(diag_r), .done(div_done), .quotient(quo)
  );

  // read pointer: column for the sweep, diagonal scan index in check
  assign rd_j = j_r;

  always_ff @(posedge clk) begin
    if (wr_en && wr_sel == gss_pkg::CMD_COEFF) begin
      coeff_mem[wr_addr] <= wr_data;
    end
    if (wr_en && wr_sel == gss_pkg::CMD_RHS) begin
      rhs_mem[wr_addr[3:0]] <= wr_data;
    end
    if (sol_we) begin
      sol_mem[sol_wa] <= sol_wd;
    end
    a_rd_r   <= coeff_mem[(st_r == S_DCHK) ? {rd_j[3:0], rd_j[3:0]} : {i_r, rd_j[3:0]}];
    x_rd_r   <= sol_mem[(st_r == S_RPT || st_r == S_RPTW) ? i_r : rd_j[3:0]];
    rhs_rd_r <= rhs_mem[i_r];
  end

  assign sol_we = (wr_en && wr_sel == gss_pkg::CMD_GUESS) || (st_r == S_DIV && div_done);
  assign sol_wa = (st_r == S_DIV) ? i_r : wr_addr[3:0];
  assign sol_wd = (st_r == S_DIV) ? q_sat : wr_data;

  always_comb begin
    if (quo > 64'sh7FFF_FFFF) begin
      q_sat = 32'sh7FFF_FFFF;
    end else if (quo < -64'sh8000_0000) begin
      q_sat = 32'sh8000_0000;
    end else begin
      q_sat = quo[31:0];
    end
    dlt  = 34'(q_sat) - 34'(old_r);
    dabs = dlt[33] ? 34'(-dlt) : 34'(dlt);
  end

  always_comb begin
    if (prod_r > 0 && acc_r < -gss_pkg::ACC_MAX + prod_r) begin
      acc_sub = -gss_pkg::ACC_MAX;
    end else if (prod_r < 0 && acc_r > gss_pkg::ACC_MAX + prod_r) begin
      acc_sub = gss_pkg::ACC_MAX;
    end else begin
      acc_sub = acc_r - prod_r;
    end
  end

  assign last_i = ({1'b0, i_r} == jb_r.n - 5'd1);

  always_comb begin
    st_nxt    = st_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    sw_nxt    = sw_r;
    set_nxt   = set_r;
    stat_nxt  = stat_r;
    acc_nxt   = acc_r;
    zd_nxt    = zd_r;
    ov_nxt    = 1'b0;
    ow_nxt    = ow_r;
    div_go    = 1'b0;
    job_taken = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          job_taken = 1'b1;
          st_nxt    = S_DCHK;
          j_nxt     = '0;
          zd_nxt    = 1'b0;
          sw_nxt    = '0;
        end
      end
      S_DCHK: begin
        // a_rd_r holds diagonal j_r-1
        if (j_r != 5'd0 && a_rd_r == 32'sd0) begin
          zd_nxt = 1'b1;
        end
        if (j_r == jb_r.n) begin
          i_nxt = '0;
          if (zd_r || (j_r != 5'd0 && a_rd_r == 32'sd0)) begin
            stat_nxt = gss_pkg::ST_ZDIAG;
            st_nxt   = S_RPT;
          end else begin
            set_nxt = '0;
            j_nxt   = '0;
            st_nxt  = S_INIT;
          end
        end else begin
          j_nxt = j_r + 5'd1;
        end
      end
      S_INIT: begin
        // wait for the rhs/old/diag reads to land
        if (j_r == 5'd1) begin
          acc_nxt = 64'(rhs_rd_r) <<< 16;
          j_nxt   = '0;
          st_nxt  = S_MAC;
        end else begin
          j_nxt = j_r + 5'd1;
        end
      end
      S_MAC: begin
        if (prod_v_r) begin
          acc_nxt = acc_sub;
        end
        if (j_r == jb_r.n + 5'd1) begin
          st_nxt = S_MUL;
        end else begin
          j_nxt = j_r + 5'd1;
        end
      end
      S_MUL: begin
        if (prod_v_r) begin
          acc_nxt = acc_sub;
        end
        st_nxt = S_DIV;
        div_go = 1'b1;
      end
      S_DIV: begin
        if (div_done) begin
          if (dabs <= {3'd0, jb_r.tol}) begin
            set_nxt = set_r + 5'd1;
          end
          j_nxt = '0;
          if (last_i) begin
            sw_nxt = sw_r + 29'd1;
            i_nxt  = '0;
            if ((set_r + ((dabs <= {3'd0, jb_r.tol}) ? 5'd1 : 5'd0)) == jb_r.n) begin
              stat_nxt = gss_pkg::ST_CONV;
              st_nxt   = S_RPT;
            end else if (sw_r + 29'd1 > {1'b0, jb_r.max_sweeps}) begin
              stat_nxt = gss_pkg::ST_LIMIT;
              st_nxt   = S_RPT;
            end else begin
              set_nxt = '0;
              st_nxt  = S_INIT;
            end
          end else begin
            i_nxt  = i_r + 4'd1;
            st_nxt = S_INIT;
          end
        end
      end
      S_RPT: begin
        st_nxt = S_RPTW;
      end
      S_RPTW: begin
        ov_nxt = 1'b1;
        ow_nxt = '{var_index: i_r, solution: x_rd_r, status: stat_r,
                   sweeps: sw_r, last: last_i};
        if (last_i) begin
          st_nxt = S_IDLE;
        end else begin
          i_nxt  = i_r + 4'd1;
          st_nxt = S_RPT;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ov_r     <= 1'b0;
      prod_v_r <= 1'b0;
      sw_r     <= '0;
      set_r    <= '0;
    end else begin
      st_r     <= st_nxt;
      ov_r     <= ov_nxt;
      // product of column j_r-1 read last cycle, skipping the diagonal
      prod_v_r <= (st_r == S_MAC) && j_r != 5'd0 && j_r <= jb_r.n &&
                  (j_r - 5'd1) != {1'b0, i_r};
      sw_r     <= sw_nxt;
      set_r    <= set_nxt;
    end
    if (st_r == S_IDLE && job_valid) begin
      jb_r <= job;
    end
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    stat_r <= stat_nxt;
    acc_r  <= acc_nxt;
    zd_r   <= zd_nxt;
    ow_r   <= ow_nxt;
    prod_r <= 64'(a_rd_r) * 64'(x_rd_r);
    if (st_r == S_INIT) begin
      old_r <= sol_mem[i_r];
      if (j_r == 5'd0) begin
        diag_r <= coeff_mem[{i_r, i_r}];
      end
    end
  end

  assign idle      = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_word  = ow_r;

endmodule

// File: design/gauss_seidel_solver_core.sv
// top level of the gauss-seidel solver
// usage: command words enter on in_word with start; a word is taken when start
// is high and busy is low. load words (coefficient, right-hand side, initial
// guess) write the stores and produce no result. a start word
// runs sweeps over variables 0..n-1 in signed q16.16 and then emits one
// result word per variable on out_word, each marked by out_valid for one
// cycle, last set on variable n-1. the receiver cannot stall.
// sequence: a start first checks the diagonal; on a zero entry it reports
// at once with the zero-diagonal status, else per variable it subtracts the
// off-diagonal products, made on one shared multiplier, and then divides in
// a 64-step shift-subtract divider; reporting emits the variables in order.
// busy stays high from a start word until its last result has left.
// configuration: cfg_we with cfg_index 0 size, 1 tolerance, 2 sweep limit,
// to be written by the user only while busy is low; not enforced by the block.
// reset: synchronous active-low rst_n restores register defaults and
// returns to idle; store contents are undefined until written.
`timescale 1ns / 1ps
module gauss_seidel_solver_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gss_pkg::in_word_t   in_word,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  output logic                out_valid,
  output gss_pkg::out_word_t  out_word
);

  logic [4:0]         size_r;
  logic [30:0]        tol_r;
  logic [27:0]        maxs_r;
  logic               wr_en;
  logic [1:0]         wr_sel;
  logic [7:0]         wr_addr;
  logic signed [31:0] wr_data;
  logic               job_valid, job_taken, back_idle;
  gss_pkg::job_t      job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= gss_pkg::SIZE_RST;
      tol_r  <= gss_pkg::TOL_RST;
      maxs_r <= gss_pkg::MAXS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        gss_pkg::REG_SIZE: size_r <= cfg_data[4:0];
        gss_pkg::REG_TOL:  tol_r  <= cfg_data;
        gss_pkg::REG_MAXS: maxs_r <= cfg_data[27:0];
        default: ;
      endcase
    end
  end

  gss_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .in_word(in_word),
    .size_cfg(size_r), .tol_cfg(tol_r), .maxs_cfg(maxs_r),
    .job_taken(job_taken), .back_idle(back_idle), .busy(busy),
    .wr_en(wr_en), .wr_sel(wr_sel), .wr_addr(wr_addr), .wr_data(wr_data),
    .job_valid(job_valid), .job(job)
  );

  gss_back u_back (
    .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_sel(wr_sel),
    .wr_addr(wr_addr), .wr_data(wr_data), .job_valid(job_valid), .job(job),
    .job_taken(job_taken), .idle(back_idle), .out_valid(out_valid),
    .out_word(out_word)
  );

`ifndef NO_ASSERTIONS
  a_busy_out : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result while not busy");
  a_last_ends : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |=> !out_valid) else $error("result after last");
  a_no_write_busy : assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> busy) else $error("queued start while not busy");
`endif

endmodule
